FILE: design/rsc_pkg.sv
// Shared types, encodings and sizes for the RV32I subset core.
`timescale 1ns / 1ps
`default_nettype none
package rsc_pkg;

  // Data store size in words; kept a power of two so the word index is a bit slice.
  localparam int DATA_WORDS = 4096;
  localparam int DMEM_AW    = $clog2(DATA_WORDS);

  localparam int XLEN = 32;
  localparam int RIDX = 5;
  localparam int NREG = 32;

  // Major opcodes
  localparam logic [6:0] OPC_R    = 7'b0110011;
  localparam logic [6:0] OPC_I    = 7'b0010011;
  localparam logic [6:0] OPC_LW   = 7'b0000011;
  localparam logic [6:0] OPC_SW   = 7'b0100011;
  localparam logic [6:0] OPC_BR   = 7'b1100011;
  localparam logic [6:0] OPC_JALR = 7'b1100111;
  localparam logic [6:0] OPC_HALT = 7'b0000000;

  // funct3 codes
  localparam logic [2:0] F3_ADD = 3'b000;
  localparam logic [2:0] F3_XOR = 3'b100;
  localparam logic [2:0] F3_SRA = 3'b101;
  localparam logic [2:0] F3_AND = 3'b111;

  localparam logic [XLEN-1:0] PC_STEP = 32'd4;

  // Register file write / forwarding bundle
  typedef struct packed {
    logic            en;
    logic [RIDX-1:0] idx;
    logic [XLEN-1:0] val;
  } wb_t;

  // Execute unit results for one instruction
  typedef struct packed {
    logic [XLEN-1:0]    pc_nxt;
    logic               halt_nxt;
    logic               wr;
    logic [RIDX-1:0]    rd;
    logic [XLEN-1:0]    val;
    logic               ld;
    logic               st;
    logic [DMEM_AW-1:0] addr;
    logic [XLEN-1:0]    st_data;
  } exec_t;

endpackage
`default_nettype wire

FILE: design/rsc_if.sv
// Valid/ready channel interfaces for the request and result sides of the core.
`timescale 1ns / 1ps
`default_nettype none
interface rsc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [31:0]              instr_word;
  logic [rsc_pkg::RIDX-1:0] reg_index;

  modport source (output valid, req_type, instr_word, reg_index, input ready);
  modport sink   (input valid, req_type, instr_word, reg_index, output ready);
endinterface

interface rsc_out_if;
  logic                     valid;
  logic                     ready;
  logic [31:0]              pc_after;
  logic                     halted;
  logic signed [31:0]       read_data;
  logic                     reg_written;
  logic [rsc_pkg::RIDX-1:0] written_index;
  logic signed [31:0]       written_value;

  modport source (output valid, pc_after, halted, read_data, reg_written, written_index,
                  written_value, input ready);
  modport sink   (input valid, pc_after, halted, read_data, reg_written, written_index,
                  written_value, output ready);
endinterface
`default_nettype wire

FILE: design/rsc_regfile.sv
// Register file with per-entry valid bits, two registered read ports and write bypass.
`timescale 1ns / 1ps
`default_nettype none
module rsc_regfile (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             rd_en,
  input  wire logic [rsc_pkg::RIDX-1:0]         raddr_a,
  input  wire logic [rsc_pkg::RIDX-1:0]         raddr_b,
  input  wire rsc_pkg::wb_t                     wr,
  output logic      [rsc_pkg::XLEN-1:0]         rdata_a,
  output logic      [rsc_pkg::XLEN-1:0]         rdata_b
);

  logic [rsc_pkg::XLEN-1:0] mem_r [rsc_pkg::NREG];
  logic [rsc_pkg::NREG-1:0] valid_r;
  logic [rsc_pkg::XLEN-1:0] rdata_a_r;
  logic [rsc_pkg::XLEN-1:0] rdata_b_r;

  // Track which entries hold written data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.idx] <= 1'b1;
    end
  end

  // Write storage and capture read data; unwritten entries read as zero and a
  // write on the same edge is passed through
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.idx] <= wr.val;
    end
    if (rd_en) begin
      if (wr.en && wr.idx == raddr_a) begin
        rdata_a_r <= wr.val;
      end else begin
        rdata_a_r <= valid_r[raddr_a] ? mem_r[raddr_a] : '0;
      end
      if (wr.en && wr.idx == raddr_b) begin
        rdata_b_r <= wr.val;
      end else begin
        rdata_b_r <= valid_r[raddr_b] ? mem_r[raddr_b] : '0;
      end
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule
`default_nettype wire

FILE: design/rsc_dmem.sv
// Word-indexed data store with a clearing sweep after reset and registered read.
`timescale 1ns / 1ps
`default_nettype none
module rsc_dmem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic                        wr_en,
  input  wire logic [rsc_pkg::DMEM_AW-1:0] addr,
  input  wire logic [rsc_pkg::XLEN-1:0]    wdata,
  output logic      [rsc_pkg::XLEN-1:0]    rdata,
  output logic                             clr_done
);

  localparam logic [rsc_pkg::DMEM_AW-1:0] LAST_WORD =
    rsc_pkg::DMEM_AW'(rsc_pkg::DATA_WORDS - 1);
  localparam logic [rsc_pkg::DMEM_AW-1:0] ONE_WORD = rsc_pkg::DMEM_AW'(1);

  logic [rsc_pkg::XLEN-1:0]    mem_r [rsc_pkg::DATA_WORDS];
  logic [rsc_pkg::DMEM_AW-1:0] clr_cnt_r;
  logic [rsc_pkg::DMEM_AW-1:0] clr_cnt_nxt;
  logic                        clr_done_r;
  logic                        clr_done_nxt;
  logic [rsc_pkg::XLEN-1:0]    rdata_r;

  // Step the sweep one word per cycle until the last word is cleared
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_done_nxt = clr_done_r;
    if (!clr_done_r) begin
      clr_cnt_nxt = clr_cnt_r + ONE_WORD;
      if (clr_cnt_r == LAST_WORD) clr_done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_done_r <= clr_done_nxt;
    end
  end

  // Single write port shared by the sweep and stores
  always_ff @(posedge clk) begin
    if (!clr_done_r) begin
      mem_r[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem_r[addr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata    = rdata_r;
  assign clr_done = clr_done_r;

endmodule
`default_nettype wire

FILE: design/rsc_exec.sv
// Decode and execute of one instruction: ALU, branch compare, next PC, memory address.
`timescale 1ns / 1ps
`default_nettype none
module rsc_exec (
  input  wire logic                     req,
  input  wire logic [31:0]              instr,
  input  wire logic [rsc_pkg::XLEN-1:0] op_a,
  input  wire logic [rsc_pkg::XLEN-1:0] op_b,
  input  wire logic [rsc_pkg::XLEN-1:0] pc,
  input  wire logic                     halt,
  output rsc_pkg::exec_t                res
);

  logic [6:0]               opc;
  logic [2:0]               f3;
  logic [rsc_pkg::XLEN-1:0] imm_i;
  logic [rsc_pkg::XLEN-1:0] imm_s;
  logic [rsc_pkg::XLEN-1:0] imm_b;
  logic [rsc_pkg::XLEN-1:0] sum_i;
  logic [rsc_pkg::XLEN-1:0] sum_s;
  logic [rsc_pkg::XLEN-1:0] ea;
  logic [rsc_pkg::XLEN-1:0] pc_inc;

  // Field and immediate extraction
  always_comb begin
    opc    = instr[6:0];
    f3     = instr[14:12];
    imm_i  = {{20{instr[31]}}, instr[31:20]};
    imm_s  = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    imm_b  = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    sum_i  = op_a + imm_i;
    sum_s  = op_a + imm_s;
    ea     = (opc == rsc_pkg::OPC_SW) ? sum_s : sum_i;
    pc_inc = pc + rsc_pkg::PC_STEP;
  end

  // Execute; read requests and a halted core leave all state alone
  always_comb begin
    res          = '0;
    res.pc_nxt   = pc;
    res.halt_nxt = halt;
    res.rd       = instr[11:7];
    res.addr     = ea[rsc_pkg::DMEM_AW-1:0];
    res.st_data  = op_b;
    if (!req && !halt) begin
      res.pc_nxt = pc_inc;
      case (opc)
        rsc_pkg::OPC_HALT: res.halt_nxt = 1'b1;
        rsc_pkg::OPC_R: begin
          case (f3)
            rsc_pkg::F3_ADD: begin
              res.wr  = 1'b1;
              res.val = instr[30] ? (op_a - op_b) : (op_a + op_b);
            end
            rsc_pkg::F3_XOR: begin
              res.wr  = 1'b1;
              res.val = op_a ^ op_b;
            end
            rsc_pkg::F3_SRA: begin
              res.wr  = 1'b1;
              res.val = $unsigned($signed(op_a) >>> op_b[4:0]);
            end
            default: ;
          endcase
        end
        rsc_pkg::OPC_I: begin
          case (f3)
            rsc_pkg::F3_ADD: begin
              res.wr  = 1'b1;
              res.val = sum_i;
            end
            rsc_pkg::F3_AND: begin
              res.wr  = 1'b1;
              res.val = op_a & imm_i;
            end
            default: ;
          endcase
        end
        rsc_pkg::OPC_LW: begin
          res.wr = 1'b1;
          res.ld = 1'b1;
        end
        rsc_pkg::OPC_SW: res.st = 1'b1;
        rsc_pkg::OPC_BR: begin
          if ($signed(op_a) < $signed(op_b)) res.pc_nxt = pc + imm_b;
        end
        rsc_pkg::OPC_JALR: begin
          res.wr     = 1'b1;
          res.val    = pc_inc;
          res.pc_nxt = {sum_i[rsc_pkg::XLEN-1:1], 1'b0};
        end
        default: ;
      endcase
      // Drop writes to x0
      if (res.rd == '0) res.wr = 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: design/riscv_subset_single_cycle_core.sv
// Top level of the RV32I subset core: pipeline registers, forwarding and handshakes.
//
//   channel  dir  handshake            contents
//   in_ch    in   valid/ready          req_type, instr_word, reg_index
//   out_ch   out  valid/ready          pc_after, halted, read_data, reg_written,
//                                      written_index, written_value
//
// One transaction per cycle sustained while out_ch takes results; each taken request
// moves through the register read stage, execute/memory stage and result register.
// After reset the data store is swept to zero, one word a cycle, with in_ch.ready low
// until the sweep is done.
// A held result stalls the pipeline back to in_ch.ready; up to three transactions are in
// flight. Load data is forwarded from the memory read register to the next instruction.
`timescale 1ns / 1ps
`default_nettype none
module riscv_subset_single_cycle_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rsc_in_if.sink     in_ch,
  rsc_out_if.source  out_ch
);

  // Handshake and control
  logic in_fire;
  logic s1_adv;
  logic s2_adv;
  logic out_free;
  logic clr_done;

  // Architectural state
  logic [rsc_pkg::XLEN-1:0] pc_r;
  logic                     halt_r;

  // Read stage
  logic                     s1_valid_r;
  logic                     s1_req_r;
  logic [31:0]              s1_instr_r;
  logic [rsc_pkg::RIDX-1:0] s1_rsa_r;
  logic [rsc_pkg::XLEN-1:0] rf_a;
  logic [rsc_pkg::XLEN-1:0] rf_b;
  logic [rsc_pkg::XLEN-1:0] op_a;
  logic [rsc_pkg::XLEN-1:0] op_b;
  logic [rsc_pkg::RIDX-1:0] rsa_in;
  rsc_pkg::exec_t           ex;

  // Execute/memory stage
  logic                     s2_valid_r;
  logic [rsc_pkg::XLEN-1:0] s2_pc_r;
  logic                     s2_halt_r;
  logic [rsc_pkg::XLEN-1:0] s2_read_r;
  logic                     s2_wr_r;
  logic [rsc_pkg::RIDX-1:0] s2_rd_r;
  logic [rsc_pkg::XLEN-1:0] s2_val_r;
  logic                     s2_ld_r;
  logic [rsc_pkg::XLEN-1:0] s2_wval;
  logic [rsc_pkg::XLEN-1:0] mem_rdata;
  rsc_pkg::wb_t             rf_wr;

  // Result register
  logic                     out_valid_r;
  logic [rsc_pkg::XLEN-1:0] out_pc_r;
  logic                     out_halt_r;
  logic [rsc_pkg::XLEN-1:0] out_read_r;
  logic                     out_wr_r;
  logic [rsc_pkg::RIDX-1:0] out_idx_r;
  logic [rsc_pkg::XLEN-1:0] out_val_r;

  // Stage advance chain
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s2_adv       = s2_valid_r && out_free;
  assign s1_adv       = s1_valid_r && (!s2_valid_r || s2_adv);
  assign in_ch.ready  = clr_done && (!s1_valid_r || s1_adv);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign rsa_in       = in_ch.req_type ? in_ch.reg_index : in_ch.instr_word[19:15];

  // Writeback from the execute/memory stage
  assign s2_wval   = s2_ld_r ? mem_rdata : s2_val_r;
  assign rf_wr.en  = s2_adv && s2_wr_r;
  assign rf_wr.idx = s2_rd_r;
  assign rf_wr.val = s2_wval;

  rsc_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .raddr_a (rsa_in),
    .raddr_b (in_ch.instr_word[24:20]),
    .wr      (rf_wr),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  // Forward the pending write of the older instruction
  always_comb begin
    op_a = rf_a;
    op_b = rf_b;
    if (s2_valid_r && s2_wr_r && s2_rd_r == s1_rsa_r)           op_a = s2_wval;
    if (s2_valid_r && s2_wr_r && s2_rd_r == s1_instr_r[24:20])  op_b = s2_wval;
  end

  rsc_exec u_exec (
    .req   (s1_req_r),
    .instr (s1_instr_r),
    .op_a  (op_a),
    .op_b  (op_b),
    .pc    (pc_r),
    .halt  (halt_r),
    .res   (ex)
  );

  rsc_dmem u_dmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (s1_adv),
    .wr_en    (s1_adv && ex.st),
    .addr     (ex.addr),
    .wdata    (ex.st_data),
    .rdata    (mem_rdata),
    .clr_done (clr_done)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      halt_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        pc_r   <= ex.pc_nxt;
        halt_r <= ex.halt_nxt;
      end
      if (in_fire)        s1_valid_r <= 1'b1;
      else if (s1_adv)    s1_valid_r <= 1'b0;
      if (s1_adv)         s2_valid_r <= 1'b1;
      else if (s2_adv)    s2_valid_r <= 1'b0;
      if (s2_adv)         out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r   <= in_ch.req_type;
      s1_instr_r <= in_ch.instr_word;
      s1_rsa_r   <= rsa_in;
    end
    if (s1_adv) begin
      s2_pc_r   <= ex.pc_nxt;
      s2_halt_r <= ex.halt_nxt;
      s2_read_r <= s1_req_r ? op_a : '0;
      s2_wr_r   <= ex.wr;
      s2_rd_r   <= ex.rd;
      s2_val_r  <= ex.val;
      s2_ld_r   <= ex.ld;
    end
    if (s2_adv) begin
      out_pc_r   <= s2_pc_r;
      out_halt_r <= s2_halt_r;
      out_read_r <= s2_read_r;
      out_wr_r   <= s2_wr_r;
      out_idx_r  <= s2_wr_r ? s2_rd_r : '0;
      out_val_r  <= s2_wr_r ? s2_wval : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pc_after      = out_pc_r;
  assign out_ch.halted        = out_halt_r;
  assign out_ch.read_data     = $signed(out_read_r);
  assign out_ch.reg_written   = out_wr_r;
  assign out_ch.written_index = out_idx_r;
  assign out_ch.written_value = $signed(out_val_r);

  // x0 is never written
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_wr.en |-> rf_wr.idx != '0)
    else $error("register x0 written");

  // No request taken while the data store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done |-> !in_ch.ready)
    else $error("request accepted during data store clear");

  // A halted core keeps its halt flag and pc
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r && $stable(pc_r))
    else $error("halted core changed state");

  // A register read request leaves the pc unchanged
  a_read_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_req_r |=> $stable(pc_r))
    else $error("read request moved the pc");

endmodule
`default_nettype wire
